// ===== hdl/cursor_linked_list_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linked list engine
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("linked list engine assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("linked list engine assertion failed");

`endif

// ===== hdl/clle_pkg.sv =====
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types, constants and helpers of the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

	localparam int NODE_COUNT = 256;
	localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int ACT_W      = 4;
	localparam int NODE_W     = 8;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR       = 4'd0,
		ACT_FIRST       = 4'd1,
		ACT_LAST        = 4'd2,
		ACT_NEXT        = 4'd3,
		ACT_NEXT_WRAP   = 4'd4,
		ACT_PREV        = 4'd5,
		ACT_PREV_WRAP   = 4'd6,
		ACT_SEEK        = 4'd7,
		ACT_REMOVE_CUR  = 4'd8,
		ACT_REMOVE_NODE = 4'd9,
		ACT_INS_AFTER   = 4'd10,
		ACT_INS_BEFORE  = 4'd11,
		ACT_APPEND      = 4'd12,
		ACT_PREPEND     = 4'd13,
		ACT_REPLACE     = 4'd14,
		ACT_QUERY       = 4'd15
	} action_t;

	// One port pair of a link memory: a read address and a write.
	typedef struct packed {
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		idx_t wr_data;
	} mem_req_t;

	typedef struct packed {
		logic  valid;
		logic  ok;
		logic  is_empty;
		node_t head_node;
		node_t cursor_node;
	} result_t;

	function automatic idx_t to_idx(node_t n);
		logic [IDX_W+NODE_W-1:0] w;
		w = {{IDX_W{1'b0}}, n};
		return w[IDX_W-1:0];
	endfunction

	function automatic node_t to_node(idx_t i);
		logic [IDX_W+NODE_W-1:0] w;
		w = {{NODE_W{1'b0}}, i};
		return w[NODE_W-1:0];
	endfunction

	function automatic logic node_ok(node_t n);
		logic [IDX_W+NODE_W:0] w;
		w = {{(IDX_W+1){1'b0}}, n};
		return w < (IDX_W+NODE_W+1)'(NODE_COUNT);
	endfunction

endpackage

// ===== hdl/clle_if.sv =====
// ----------------------------------------------------------------------------
// clle_if
// Valid/ready channels of the linked list engine: command in, result out.
// ----------------------------------------------------------------------------
interface clle_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [clle_pkg::ACT_W-1:0]   action;
	logic [clle_pkg::NODE_W-1:0]  node;

	modport source(output valid, action, node, input ready);
	modport sink(input valid, action, node, output ready);
endinterface

interface clle_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic                         is_empty;
	logic [clle_pkg::NODE_W-1:0]  head_node;
	logic [clle_pkg::NODE_W-1:0]  cursor_node;

	modport source(output valid, ok, is_empty, head_node, cursor_node, input ready);
	modport sink(input valid, ok, is_empty, head_node, cursor_node, output ready);
endinterface

// ===== hdl/clle_ram.sv =====
// ----------------------------------------------------------------------------
// clle_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/clle_seq.sv =====
// ----------------------------------------------------------------------------
// clle_seq
// Action sequencer: holds head, cursor and the nonempty flag, drives the
// forward and backward link memories and produces one result per action.
// ----------------------------------------------------------------------------
module clle_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic [3:0]         cmd_action,
	input  clle_pkg::node_t    cmd_node,
	output logic               cmd_ready,
	input  logic               slot_free,
	input  clle_pkg::idx_t     fwd_rdata,
	input  clle_pkg::idx_t     bwd_rdata,
	output clle_pkg::mem_req_t fwd_req,
	output clle_pkg::mem_req_t bwd_req,
	output clle_pkg::result_t  fin
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXE  = 4'b0010,
		ST_SEEK = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	clle_pkg::idx_t      head_q, head_d;
	clle_pkg::idx_t      cur_q, cur_d;
	logic                full_q, full_d;
	clle_pkg::action_t   act_q, act_d;
	clle_pkg::idx_t      node_q, node_d;
	logic                ok_q, ok_d;
	logic                wb_en_q, wb_en_d;
	clle_pkg::idx_t      wb_f_q, wb_f_d;
	clle_pkg::idx_t      wb_b_q, wb_b_d;
	clle_pkg::cnt_t      cnt_q, cnt_d;

	clle_pkg::action_t   in_act;
	clle_pkg::idx_t      in_idx;
	logic                in_ok;
	clle_pkg::idx_t      f_ra, b_ra, f_wa, f_wd, b_wa, b_wd;
	logic                f_we, b_we;

	assign in_act = clle_pkg::action_t'(cmd_action);
	assign in_idx = clle_pkg::to_idx(cmd_node);
	assign in_ok  = clle_pkg::node_ok(cmd_node);

	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		cur_d   = cur_q;
		full_d  = full_q;
		act_d   = act_q;
		node_d  = node_q;
		ok_d    = ok_q;
		wb_en_d = wb_en_q;
		wb_f_d  = wb_f_q;
		wb_b_d  = wb_b_q;
		cnt_d   = cnt_q;
		f_we    = 1'b0;
		f_wa    = node_q;
		f_wd    = wb_f_q;
		b_we    = 1'b0;
		b_wa    = node_q;
		b_wd    = wb_b_q;
		f_ra    = cur_q;
		b_ra    = cur_q;
		fin     = '0;

		unique case (state_q)
			ST_IDLE: begin
				// Read addresses go out with the command so the data lands in ST_EXE or ST_SEEK.
				if (in_act == clle_pkg::ACT_SEEK) begin
					f_ra = head_q;
				end else if (in_act == clle_pkg::ACT_REMOVE_NODE) begin
					f_ra = in_idx;
				end
				if (in_act == clle_pkg::ACT_LAST || in_act == clle_pkg::ACT_APPEND ||
					in_act == clle_pkg::ACT_PREPEND) begin
					b_ra = head_q;
				end else if (in_act == clle_pkg::ACT_REMOVE_NODE) begin
					b_ra = in_idx;
				end
				if (cmd_valid) begin
					act_d   = in_act;
					node_d  = in_idx;
					ok_d    = 1'b0;
					wb_en_d = 1'b0;
					cnt_d   = clle_pkg::cnt_t'(1);
					state_d = ST_FIN;
					unique case (in_act)
						clle_pkg::ACT_CLEAR: begin
							full_d = 1'b0;
							head_d = '0;
							cur_d  = '0;
						end
						clle_pkg::ACT_FIRST: begin
							if (full_q) begin
								cur_d = head_q;
								ok_d  = 1'b1;
							end
						end
						clle_pkg::ACT_LAST, clle_pkg::ACT_NEXT, clle_pkg::ACT_NEXT_WRAP,
						clle_pkg::ACT_PREV_WRAP: begin
							if (full_q) begin
								state_d = ST_EXE;
							end
						end
						clle_pkg::ACT_REMOVE_CUR: begin
							node_d = cur_q;
							if (full_q) begin
								state_d = ST_EXE;
							end
						end
						clle_pkg::ACT_PREV: begin
							if (full_q && cur_q != head_q) begin
								state_d = ST_EXE;
							end
						end
						clle_pkg::ACT_SEEK: begin
							if (in_ok && full_q) begin
								if (head_q == in_idx) begin
									cur_d = head_q;
									ok_d  = 1'b1;
								end else begin
									state_d = ST_SEEK;
								end
							end
						end
						clle_pkg::ACT_REMOVE_NODE, clle_pkg::ACT_REPLACE: begin
							if (in_ok && full_q) begin
								state_d = ST_EXE;
							end
						end
						clle_pkg::ACT_INS_AFTER, clle_pkg::ACT_INS_BEFORE,
						clle_pkg::ACT_APPEND, clle_pkg::ACT_PREPEND: begin
							if (in_ok) begin
								if (full_q) begin
									state_d = ST_EXE;
								end else begin
									// Empty list: the node becomes a one-node ring.
									head_d  = in_idx;
									cur_d   = in_idx;
									full_d  = 1'b1;
									wb_en_d = 1'b1;
									wb_f_d  = in_idx;
									wb_b_d  = in_idx;
								end
							end
						end
						clle_pkg::ACT_QUERY: begin
						end
					endcase
				end
			end
			ST_EXE: begin
				state_d = ST_FIN;
				unique case (act_q)
					clle_pkg::ACT_LAST, clle_pkg::ACT_PREV, clle_pkg::ACT_PREV_WRAP: begin
						cur_d = bwd_rdata;
						ok_d  = 1'b1;
					end
					clle_pkg::ACT_NEXT: begin
						if (fwd_rdata != head_q) begin
							cur_d = fwd_rdata;
							ok_d  = 1'b1;
						end
					end
					clle_pkg::ACT_NEXT_WRAP: begin
						cur_d = fwd_rdata;
						ok_d  = 1'b1;
					end
					clle_pkg::ACT_REMOVE_CUR, clle_pkg::ACT_REMOVE_NODE: begin
						if (bwd_rdata == node_q) begin
							full_d = 1'b0;
							head_d = '0;
							cur_d  = '0;
						end else begin
							f_we = 1'b1;
							f_wa = bwd_rdata;
							f_wd = fwd_rdata;
							b_we = 1'b1;
							b_wa = fwd_rdata;
							b_wd = bwd_rdata;
							if (head_q == node_q) begin
								head_d = fwd_rdata;
							end
							if (act_q == clle_pkg::ACT_REMOVE_CUR || node_q == cur_q) begin
								cur_d = fwd_rdata;
							end
						end
					end
					clle_pkg::ACT_INS_AFTER: begin
						f_we    = 1'b1;
						f_wa    = cur_q;
						f_wd    = node_q;
						b_we    = 1'b1;
						b_wa    = fwd_rdata;
						b_wd    = node_q;
						wb_en_d = 1'b1;
						wb_f_d  = fwd_rdata;
						wb_b_d  = cur_q;
						cur_d   = node_q;
					end
					clle_pkg::ACT_INS_BEFORE: begin
						b_we    = 1'b1;
						b_wa    = cur_q;
						b_wd    = node_q;
						f_we    = 1'b1;
						f_wa    = bwd_rdata;
						f_wd    = node_q;
						wb_en_d = 1'b1;
						wb_f_d  = cur_q;
						wb_b_d  = bwd_rdata;
						if (cur_q == head_q) begin
							head_d = node_q;
						end
						cur_d = node_q;
					end
					clle_pkg::ACT_APPEND, clle_pkg::ACT_PREPEND: begin
						f_we    = 1'b1;
						f_wa    = bwd_rdata;
						f_wd    = node_q;
						b_we    = 1'b1;
						b_wa    = head_q;
						b_wd    = node_q;
						wb_en_d = 1'b1;
						wb_f_d  = head_q;
						wb_b_d  = bwd_rdata;
						if (act_q == clle_pkg::ACT_PREPEND) begin
							head_d = node_q;
						end
					end
					clle_pkg::ACT_REPLACE: begin
						wb_en_d = 1'b1;
						if (bwd_rdata == cur_q) begin
							head_d = node_q;
							cur_d  = node_q;
							wb_f_d = node_q;
							wb_b_d = node_q;
						end else begin
							f_we   = 1'b1;
							f_wa   = bwd_rdata;
							f_wd   = node_q;
							b_we   = 1'b1;
							b_wa   = fwd_rdata;
							b_wd   = node_q;
							wb_f_d = fwd_rdata;
							wb_b_d = bwd_rdata;
							if (head_q == cur_q) begin
								head_d = node_q;
							end
							cur_d = node_q;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SEEK: begin
				// Each cycle checks one link and fetches the next one.
				f_ra = fwd_rdata;
				if (fwd_rdata == head_q || cnt_q == clle_pkg::cnt_t'(clle_pkg::NODE_COUNT)) begin
					state_d = ST_FIN;
				end else if (fwd_rdata == node_q) begin
					cur_d   = fwd_rdata;
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + clle_pkg::cnt_t'(1);
				end
			end
			ST_FIN: begin
				// Second write pass targets the given node; repeating it while stalled is harmless.
				f_we = wb_en_q;
				b_we = wb_en_q;
				if (slot_free) begin
					fin.valid       = 1'b1;
					fin.ok          = ok_q;
					fin.is_empty    = !full_q;
					fin.head_node   = full_q ? clle_pkg::to_node(head_q) : '0;
					fin.cursor_node = full_q ? clle_pkg::to_node(cur_q) : '0;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fwd_req = '{rd_addr: f_ra, wr_en: f_we, wr_addr: f_wa, wr_data: f_wd};
	assign bwd_req = '{rd_addr: b_ra, wr_en: b_we, wr_addr: b_wa, wr_data: b_wd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cur_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cur_q   <= cur_d;
			full_q  <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q   <= act_d;
		node_q  <= node_d;
		ok_q    <= ok_d;
		wb_en_q <= wb_en_d;
		wb_f_q  <= wb_f_d;
		wb_b_q  <= wb_b_d;
		cnt_q   <= cnt_d;
	end

endmodule

// ===== hdl/cursor_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit
// Circular doubly linked list over a node pool, with head and cursor.
//
//   channel  dir  fields                                   word accepted
//   cmd      in   action[3:0], node[7:0]                   valid & ready
//   rsp      out  ok, is_empty, head_node[7:0],            valid & ready
//                 cursor_node[7:0]
//
// Clear, first, query, a seek that finds the head, an insert into an empty
// list and any action that has nothing to do go from acceptance straight to
// the final state; the other navigation, removes, inserts and replace first
// read the link memories and do the first write-back pass in the execute state.
// A seek walks the forward links from the head instead, at most NODE_COUNT of them.
// Reset clears head, cursor and the nonempty flag; link memories are not cleared.
// A stalled result holds in the output register; the next command is taken
// meanwhile and waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit (
	input logic        clk,
	input logic        arst_n,
	clle_cmd_if.sink   cmd,
	clle_rsp_if.source rsp
);

	clle_pkg::mem_req_t fwd_req, bwd_req;
	clle_pkg::idx_t     fwd_rdata, bwd_rdata;
	clle_pkg::result_t  fin;
	clle_pkg::result_t  res_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || rsp.ready;

	clle_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_action (cmd.action),
		.cmd_node   (cmd.node),
		.cmd_ready  (cmd.ready),
		.slot_free  (slot_free),
		.fwd_rdata  (fwd_rdata),
		.bwd_rdata  (bwd_rdata),
		.fwd_req    (fwd_req),
		.bwd_req    (bwd_req),
		.fin        (fin)
	);

	clle_ram #(
		.WIDTH (clle_pkg::IDX_W),
		.DEPTH (clle_pkg::NODE_COUNT)
	) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_req.wr_en),
		.waddr (fwd_req.wr_addr),
		.wdata (fwd_req.wr_data),
		.raddr (fwd_req.rd_addr),
		.rdata (fwd_rdata)
	);

	clle_ram #(
		.WIDTH (clle_pkg::IDX_W),
		.DEPTH (clle_pkg::NODE_COUNT)
	) u_bwd_ram (
		.clk   (clk),
		.we    (bwd_req.wr_en),
		.waddr (bwd_req.wr_addr),
		.wdata (bwd_req.wr_data),
		.raddr (bwd_req.rd_addr),
		.rdata (bwd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			res_q <= fin;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = res_q.ok;
	assign rsp.is_empty    = res_q.is_empty;
	assign rsp.head_node   = res_q.head_node;
	assign rsp.cursor_node = res_q.cursor_node;

endmodule

// ===== hdl/clle_checker.sv =====
// ----------------------------------------------------------------------------
// clle_checker
// Port-level checks of the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_unit_assert.svh"

module clle_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        ok,
	input logic                        is_empty,
	input logic [clle_pkg::NODE_W-1:0] head_node,
	input logic [clle_pkg::NODE_W-1:0] cursor_node
);

	// An empty list reports zero for head and cursor.
	`CLLE_ASSERT_SAME(a_empty_zero, out_valid && is_empty, head_node == '0 && cursor_node == '0)

	// A successful navigation or seek never leaves the list empty.
	`CLLE_ASSERT_SAME(a_ok_nonempty, out_valid && ok, !is_empty)

	// The engine works on one command at a time.
	`CLLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A stalled result word stays put.
	`CLLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(ok) && $stable(is_empty) && $stable(head_node) && $stable(cursor_node))

endmodule

bind cursor_linked_list_engine_unit clle_checker u_clle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.ok          (rsp.ok),
	.is_empty    (rsp.is_empty),
	.head_node   (rsp.head_node),
	.cursor_node (rsp.cursor_node)
);
